/* src/header_length_frame_deframer_unit_defines.svh */
// Assertion macros used by the deframer's scan sequencer.
`ifndef HEADER_LENGTH_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define HEADER_LENGTH_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define HLFD_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
`define HLFD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define HLFD_ASSERT_ALWAYS(label, expr, msg)
`define HLFD_ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

/* src/hlfd_pkg.sv */
// Types, constants and helpers of the header/length deframer.
`timescale 1ns / 1ps
`default_nettype none
package hlfd_pkg;
    localparam int BUFFER_BYTES_DEF = 32;
    localparam int HEADER_MAX_DEF   = 4;
    localparam int RESULT_CAP       = 64;

    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_NOISE = 2'd1;
    localparam logic [1:0] KIND_BADLEN = 2'd2;
    localparam logic [1:0] KIND_OVF   = 2'd3;

    localparam logic [2:0] REG_HDR_PAT = 3'd0;
    localparam logic [2:0] REG_HDR_LEN = 3'd1;
    localparam logic [2:0] REG_LEN_OFF = 3'd2;
    localparam logic [2:0] REG_FORMAT  = 3'd3;
    localparam logic [2:0] REG_OVH     = 3'd4;
    localparam logic [2:0] REG_MIN     = 3'd5;
    localparam logic [2:0] REG_MAX     = 3'd6;
    localparam logic [2:0] REG_PAY_ST  = 3'd7;

    localparam logic [7:0] PAY_NONE = 8'd255;

    typedef struct packed {
        logic [31:0] hdr_pat;
        logic [2:0]  hdr_len;
        logic [7:0]  len_off;
        logic [3:0]  fmt;
        logic [7:0]  ovh;
        logic [15:0] min_f;
        logic [15:0] max_f;
        logic [7:0]  pay_st;
    } t_cfg;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       pay;
        logic       fend;
        logic [5:0] drop;
    } t_res;

    function automatic logic [7:0] f_hdr_byte(input logic [31:0] pat, input logic [2:0] k);
        logic [31:0] s;
        s = pat >> {k[1:0], 3'b000};
        return s[7:0];
    endfunction
endpackage
`default_nettype wire

/* src/hlfd_cfg.sv */
// APB register file holding the deframer configuration.
`timescale 1ns / 1ps
`default_nettype none
module hlfd_cfg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output hlfd_pkg::t_cfg   o_cfg
);
    import hlfd_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_idx;

    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hdr_pat <= '0;
            r_cfg.hdr_len <= 3'd1;
            r_cfg.len_off <= '0;
            r_cfg.fmt     <= '0;
            r_cfg.ovh     <= '0;
            r_cfg.min_f   <= '0;
            r_cfg.max_f   <= 16'hFFFF;
            r_cfg.pay_st  <= PAY_NONE;
        end else if (psel && penable && pwrite && pready) begin
            case (w_idx)
                REG_HDR_PAT: r_cfg.hdr_pat <= pwdata;
                REG_HDR_LEN: r_cfg.hdr_len <= pwdata[2:0];
                REG_LEN_OFF: r_cfg.len_off <= pwdata[7:0];
                REG_FORMAT:  r_cfg.fmt     <= pwdata[3:0];
                REG_OVH:     r_cfg.ovh     <= pwdata[7:0];
                REG_MIN:     r_cfg.min_f   <= pwdata[15:0];
                REG_MAX:     r_cfg.max_f   <= pwdata[15:0];
                REG_PAY_ST:  r_cfg.pay_st  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_HDR_PAT: prdata = r_cfg.hdr_pat;
            REG_HDR_LEN: prdata = {29'd0, r_cfg.hdr_len};
            REG_LEN_OFF: prdata = {24'd0, r_cfg.len_off};
            REG_FORMAT:  prdata = {28'd0, r_cfg.fmt};
            REG_OVH:     prdata = {24'd0, r_cfg.ovh};
            REG_MIN:     prdata = {16'd0, r_cfg.min_f};
            REG_MAX:     prdata = {16'd0, r_cfg.max_f};
            REG_PAY_ST:  prdata = {24'd0, r_cfg.pay_st};
            default:     prdata = '0;
        endcase
    end
endmodule
`default_nettype wire

/* src/hlfd_store.sv */
// Byte buffer memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module hlfd_store #(
    parameter int BUFFER_BYTES = hlfd_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_we,
    input  wire logic [$clog2(BUFFER_BYTES)-1:0] i_waddr,
    input  wire logic [7:0]                      i_wdata,
    input  wire logic                            i_re,
    input  wire logic [$clog2(BUFFER_BYTES)-1:0] i_raddr,
    output logic [7:0]                           o_rdata
);
    import hlfd_pkg::*;

    logic [7:0] r_mem [BUFFER_BYTES];
    logic [7:0] r_q;

    assign o_rdata = r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

/* src/hlfd_ctrl.sv */
// Scan sequencer: header hunt, length check, frame emission and result staging.
`timescale 1ns / 1ps
`default_nettype none
`include "header_length_frame_deframer_unit_defines.svh"
module hlfd_ctrl #(
    parameter int BUFFER_BYTES = hlfd_pkg::BUFFER_BYTES_DEF,
    parameter int HEADER_MAX   = hlfd_pkg::HEADER_MAX_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire hlfd_pkg::t_cfg                  i_cfg,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [7:0]                      i_data_byte,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output hlfd_pkg::t_res                       o_res,
    output logic                                 o_run_end,
    output logic                                 o_we,
    output logic [$clog2(BUFFER_BYTES)-1:0]      o_waddr,
    output logic [7:0]                           o_wdata,
    output logic                                 o_re,
    output logic [$clog2(BUFFER_BYTES)-1:0]      o_raddr,
    input  wire logic [7:0]                      i_rdata
);
    import hlfd_pkg::*;

    localparam int AW   = $clog2(BUFFER_BYTES);
    localparam int CW   = $clog2(BUFFER_BYTES + 1);
    localparam int OW   = ((CW > 9) ? CW : 9) + 1;
    localparam int HCAP = (HEADER_MAX < 4) ? HEADER_MAX : 4;

    typedef enum logic [17:0] {
        ST_IDLE   = 18'h00001,
        ST_START  = 18'h00002,
        ST_MRD    = 18'h00004,
        ST_MCMP   = 18'h00008,
        ST_KEEP   = 18'h00010,
        ST_DROP   = 18'h00020,
        ST_FOUND  = 18'h00040,
        ST_LGATE  = 18'h00080,
        ST_LRD    = 18'h00100,
        ST_LACC   = 18'h00200,
        ST_LCHK   = 18'h00400,
        ST_PAY    = 18'h00800,
        ST_ERD    = 18'h01000,
        ST_EEMIT  = 18'h02000,
        ST_DONE   = 18'h04000,
        ST_OVF    = 18'h08000,
        ST_APPEND = 18'h10000,
        ST_FINISH = 18'h20000
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_fill;
    logic [OW-1:0] r_pos;
    logic [2:0]    r_k;
    logic [2:0]    r_cnt;
    logic [2:0]    r_keep;
    logic          r_keep_mode;
    logic [31:0]   r_enc;
    logic [15:0]   r_total;
    logic [8:0]    r_plo;
    logic [15:0]   r_phi;
    logic [7:0]    r_byte;
    logic          r_appended;
    logic          r_pend_v;
    t_res          r_pend;
    logic          r_out_v;
    t_res          r_out;
    logic          r_out_end;
    logic [6:0]    r_nres;

    logic [2:0]    w_h;
    logic [2:0]    w_fsize;
    logic [2:0]    w_keep0;
    logic [OW-1:0] w_n;
    logic [OW-1:0] w_lenreq;
    logic [32:0]   w_total;
    logic          w_bad;
    logic          w_out_free;
    logic          w_can_emit;
    logic          w_emit;
    t_res          w_res;
    logic          w_drop;
    logic [CW-1:0] w_drop_n;
    logic [OW-1:0] w_off;
    logic          w_eq;
    logic [8:0]    w_plo;
    logic [32:0]   w_pend_hi;
    logic [16:0]   w_idx;
    logic          w_last;

    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] base, input logic [AW:0] off);
        logic [AW:0] s;
        s = {1'b0, base} + off;
        if (s >= (AW+1)'(BUFFER_BYTES)) s = s - (AW+1)'(BUFFER_BYTES);
        return s[AW-1:0];
    endfunction

    function automatic logic [5:0] f_sat(input logic [CW-1:0] d);
        return (d > CW'(63)) ? 6'd63 : 6'(d);
    endfunction

    assign w_out_free = !r_out_v || i_out_ready;
    assign w_can_emit = !r_pend_v || w_out_free;
    assign o_in_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_v;
    assign o_res      = r_out;
    assign o_run_end  = r_out_end;

    always_comb begin
        if (i_cfg.hdr_len == 3'd0)          w_h = 3'd1;
        else if (i_cfg.hdr_len > 3'(HCAP))  w_h = 3'(HCAP);
        else                                w_h = i_cfg.hdr_len;
        w_fsize  = {1'b0, i_cfg.fmt[3:2]} + 3'd1;
        w_n      = OW'(r_fill);
        w_keep0  = (w_n < OW'(w_h - 3'd1)) ? r_fill[2:0] : (w_h - 3'd1);
        w_lenreq = OW'(i_cfg.len_off) + OW'(w_fsize);
        w_total  = {1'b0, r_enc} + (i_cfg.fmt[1] ? 33'(i_cfg.ovh) : 33'd0);
        w_bad    = (w_total == 33'd0) || (w_total > 33'(i_cfg.max_f)) ||
                   (w_total < 33'(i_cfg.min_f));
        w_eq     = (i_rdata == f_hdr_byte(i_cfg.hdr_pat, r_k));
        w_idx    = 17'(r_pos);
        w_last   = (w_idx + 17'd1 == 17'(r_total));
        if (i_cfg.fmt[1]) begin
            w_plo = (i_cfg.pay_st == PAY_NONE) ? 9'(w_lenreq) : 9'(i_cfg.pay_st);
        end else begin
            w_plo = (i_cfg.pay_st == PAY_NONE) ? 9'd0 : 9'(i_cfg.pay_st);
        end
        w_pend_hi = 33'(w_plo) + 33'(r_enc);
    end

    // memory ports
    always_comb begin
        case (r_state)
            ST_MRD:  w_off = r_pos + OW'(r_k);
            ST_LRD:  w_off = OW'(i_cfg.len_off) + OW'(r_k);
            ST_ERD:  w_off = r_pos;
            default: w_off = '0;
        endcase
        o_re    = (r_state == ST_MRD) || (r_state == ST_LRD) || (r_state == ST_ERD);
        o_raddr = f_wrap(r_head, (AW+1)'(w_off));
        o_we    = (r_state == ST_APPEND);
        o_waddr = f_wrap(r_head, (AW+1)'(r_fill));
        o_wdata = r_byte;
    end

    // result and drop requests of the current state
    always_comb begin
        w_emit   = 1'b0;
        w_res    = '0;
        w_drop   = 1'b0;
        w_drop_n = '0;
        case (r_state)
            ST_DROP: begin
                w_drop_n = r_fill - CW'(r_keep);
                if (w_drop_n != '0 && w_can_emit) begin
                    w_emit     = 1'b1;
                    w_res.kind = KIND_NOISE;
                    w_res.drop = f_sat(w_drop_n);
                    w_drop     = 1'b1;
                end
            end
            ST_FOUND: begin
                w_drop_n = CW'(r_pos);
                if (r_pos != '0 && w_can_emit) begin
                    w_emit     = 1'b1;
                    w_res.kind = KIND_NOISE;
                    w_res.drop = f_sat(w_drop_n);
                    w_drop     = 1'b1;
                end
            end
            ST_LCHK: begin
                w_drop_n = CW'(1);
                if (w_bad && w_can_emit) begin
                    w_emit     = 1'b1;
                    w_res.kind = KIND_BADLEN;
                    w_res.drop = 6'd1;
                    w_drop     = 1'b1;
                end
            end
            ST_OVF: begin
                w_drop_n = CW'(1);
                if (w_can_emit) begin
                    w_emit     = 1'b1;
                    w_res.kind = KIND_OVF;
                    w_res.drop = 6'd1;
                    w_drop     = 1'b1;
                end
            end
            ST_EEMIT: begin
                w_drop_n = CW'(r_total);
                if (w_can_emit) begin
                    w_emit     = 1'b1;
                    w_res.kind = KIND_FRAME;
                    w_res.data = i_rdata;
                    w_res.pay  = (w_idx >= 17'(r_plo)) && (w_idx < 17'(r_phi));
                    w_res.fend = w_last;
                    w_drop     = w_last;
                end
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_head     <= '0;
            r_fill     <= '0;
            r_appended <= 1'b0;
        end else begin
            if (w_drop) begin
                r_head <= f_wrap(r_head, (AW+1)'(w_drop_n));
                r_fill <= r_fill - w_drop_n;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_byte     <= i_data_byte;
                        r_appended <= 1'b0;
                        r_state    <= ST_START;
                    end
                end
                ST_START: begin
                    r_keep_mode <= 1'b0;
                    r_pos       <= '0;
                    r_k         <= '0;
                    r_cnt       <= w_h;
                    if (r_fill == '0) begin
                        r_state <= ST_DONE;
                    end else if (w_n >= OW'(w_h)) begin
                        r_state <= ST_MRD;
                    end else begin
                        r_keep_mode <= 1'b1;
                        r_keep      <= w_keep0;
                        r_state     <= ST_KEEP;
                    end
                end
                ST_MRD: r_state <= ST_MCMP;
                ST_MCMP: begin
                    if (w_eq && (r_k + 3'd1 == r_cnt)) begin
                        r_state <= r_keep_mode ? ST_DROP : ST_FOUND;
                    end else if (w_eq) begin
                        r_k     <= r_k + 3'd1;
                        r_state <= ST_MRD;
                    end else if (r_keep_mode) begin
                        r_keep  <= r_keep - 3'd1;
                        r_state <= ST_KEEP;
                    end else if (r_pos + OW'(1) + OW'(w_h) <= w_n) begin
                        r_pos   <= r_pos + OW'(1);
                        r_k     <= '0;
                        r_state <= ST_MRD;
                    end else begin
                        r_keep_mode <= 1'b1;
                        r_keep      <= w_keep0;
                        r_state     <= ST_KEEP;
                    end
                end
                ST_KEEP: begin
                    if (r_keep == 3'd0) begin
                        r_state <= ST_DROP;
                    end else begin
                        r_pos   <= w_n - OW'(r_keep);
                        r_cnt   <= r_keep;
                        r_k     <= '0;
                        r_state <= ST_MRD;
                    end
                end
                ST_DROP: begin
                    if (w_drop_n == '0 || w_emit) r_state <= ST_DONE;
                end
                ST_FOUND: begin
                    if (r_pos == '0) r_state <= ST_LGATE;
                    else if (w_emit) r_state <= ST_START;
                end
                ST_LGATE: begin
                    r_k   <= '0;
                    r_enc <= '0;
                    r_state <= (w_n < w_lenreq) ? ST_DONE : ST_LRD;
                end
                ST_LRD: r_state <= ST_LACC;
                ST_LACC: begin
                    if (i_cfg.fmt[0]) r_enc <= r_enc | (32'(i_rdata) << {r_k[1:0], 3'b000});
                    else              r_enc <= {r_enc[23:0], i_rdata};
                    r_k <= r_k + 3'd1;
                    r_state <= (r_k + 3'd1 == w_fsize) ? ST_LCHK : ST_LRD;
                end
                ST_LCHK: begin
                    r_total <= w_total[15:0];
                    if (w_bad) begin
                        if (w_emit) r_state <= ST_START;
                    end else if (33'(r_fill) < w_total) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_PAY;
                    end
                end
                ST_PAY: begin
                    r_plo <= w_plo;
                    if (i_cfg.fmt[1]) begin
                        r_phi <= (w_pend_hi > 33'(r_total)) ? r_total : w_pend_hi[15:0];
                    end else begin
                        r_phi <= (i_cfg.pay_st == PAY_NONE) ? 16'd0 : r_total;
                    end
                    r_pos   <= '0;
                    r_state <= ST_ERD;
                end
                ST_ERD: r_state <= ST_EEMIT;
                ST_EEMIT: begin
                    if (w_emit) begin
                        r_pos   <= r_pos + OW'(1);
                        r_state <= w_last ? ST_START : ST_ERD;
                    end
                end
                ST_DONE: begin
                    if (r_appended)                     r_state <= ST_FINISH;
                    else if (w_n >= OW'(BUFFER_BYTES)) r_state <= ST_OVF;
                    else                                r_state <= ST_APPEND;
                end
                ST_OVF: begin
                    if (w_emit) r_state <= ST_START;
                end
                ST_APPEND: begin
                    r_fill     <= r_fill + CW'(1);
                    r_appended <= 1'b1;
                    r_state    <= ST_START;
                end
                ST_FINISH: begin
                    if (!r_pend_v || w_out_free) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // one result stays pending so the last of a run can be marked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_nres   <= '0;
        end else begin
            if (r_state == ST_IDLE) r_nres <= '0;
            if (w_emit && r_nres < 7'(RESULT_CAP)) begin
                r_nres   <= r_nres + 7'd1;
                r_pend_v <= 1'b1;
                r_pend   <= w_res;
                if (r_pend_v) begin
                    r_out_v   <= 1'b1;
                    r_out     <= r_pend;
                    r_out_end <= 1'b0;
                end else if (i_out_ready) begin
                    r_out_v <= 1'b0;
                end
            end else if (r_state == ST_FINISH && r_pend_v && w_out_free) begin
                r_out_v   <= 1'b1;
                r_out     <= r_pend;
                r_out_end <= 1'b1;
                r_pend_v  <= 1'b0;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    `HLFD_ASSERT_ALWAYS(a_fill_bound, r_fill <= CW'(BUFFER_BYTES), "fill above buffer size")
    `HLFD_ASSERT_ALWAYS(a_head_bound, 32'(r_head) < BUFFER_BYTES, "head pointer out of range")
    `HLFD_ASSERT_IMPL(a_accept_clean, i_in_valid && o_in_ready, !r_pend_v, "result left pending")
    `HLFD_ASSERT_ALWAYS(a_cap, r_nres <= 7'(RESULT_CAP), "result count above cap")
endmodule
`default_nettype wire

/* src/header_length_frame_deframer_unit.sv */
// Top level of the header/length-field frame deframer.
// Scheduling: a new byte is taken only after the previous one is fully processed; a header
//   hunt reads and compares the header bytes one at a time at each position, and a byte
//   runs up to three scans (before an overflow drop, after it, after the append).
// Input: one byte at a time; stalled result beats hold the scan.
// Reset: sync active-low; clears fill level, head pointer, result staging; config to defaults.
`timescale 1ns / 1ps
`default_nettype none
module header_length_frame_deframer_unit #(
    parameter int BUFFER_BYTES = hlfd_pkg::BUFFER_BYTES_DEF,
    parameter int HEADER_MAX   = hlfd_pkg::HEADER_MAX_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input byte beats
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    // result beats
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_frame_byte,
    output logic             o_in_payload,
    output logic             o_frame_end,
    output logic [5:0]       o_drop_count,
    output logic             o_run_end
);
    import hlfd_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);

    t_cfg          w_cfg;
    t_res          w_res;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_rdata;

    // register file; the user must write it only while the block is idle; the block does not enforce this
    hlfd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // circular byte buffer; the sequencer keeps head and fill level
    hlfd_store #(.BUFFER_BYTES(BUFFER_BYTES)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // scan sequencer: hunt header, check length, emit frame, stage results
    hlfd_ctrl #(.BUFFER_BYTES(BUFFER_BYTES), .HEADER_MAX(HEADER_MAX)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (w_res),
        .o_run_end   (o_run_end),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_re        (w_re),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

    assign o_kind       = w_res.kind;
    assign o_frame_byte = w_res.data;
    assign o_in_payload = w_res.pay;
    assign o_frame_end  = w_res.fend;
    assign o_drop_count = w_res.drop;
endmodule
`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for the header/length-field frame deframer.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import hlfd_pkg::*;

    localparam int STORE_BYTES = 32;
    localparam int DRAIN_CYCLES = 600;   // worst hunt over the whole buffer, with margin
    localparam int STALL_LIMIT = 20000;  // cycles with no beat on either channel
    localparam int PHASE_COUNT = 6;
    localparam int RANDOM_BYTES = 50;    // per phase
    localparam int DEFAULT_ROWS = 6;     // directed rows run on the reset settings

    typedef struct {
        t_res r;
        logic run_end;
    } t_beat;

    // one directed row: input byte, and the expected report where it is obvious
    typedef struct {
        logic [7:0] data;
        bit         typed;
        logic [1:0] kind;
        logic [5:0] drop;
    } t_row;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_frame_byte;
    logic        o_in_payload;
    logic        o_frame_end;
    logic [5:0]  o_drop_count;
    logic        o_run_end;

    header_length_frame_deframer_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_data_byte(i_data_byte),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_kind(o_kind), .o_frame_byte(o_frame_byte), .o_in_payload(o_in_payload),
        .o_frame_end(o_frame_end), .o_drop_count(o_drop_count), .o_run_end(o_run_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Deframer shadow state: buffered bytes, fill level and live settings.
    logic [7:0] shadow_bytes[STORE_BYTES];
    int         shadow_fill;
    t_cfg       live_cfg;
    t_beat      step_beats[$];
    t_beat      pending_beats[$];

    int fail_count = 0;
    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int quiet_cycles = 0;
    int sent_count = 0;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d (t=%0t)", what, got, want, $time);
        fail_count++;
    endtask

    function automatic int hunt_len();
        int h;
        h = live_cfg.hdr_len;
        if (h == 0) h = 1;
        if (h > 4) h = 4;
        return h;
    endfunction

    function automatic bit header_at(input int pos, input int cnt);
        for (int i = 0; i < cnt; i++)
            if (shadow_bytes[pos + i] != live_cfg.hdr_pat[8*i +: 8]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void add_beat(input logic [1:0] kind, input logic [7:0] data,
                                     input bit pay, input bit fend, input int drop);
        t_beat b;
        b.r.kind = kind;
        b.r.data = data;
        b.r.pay = pay;
        b.r.fend = fend;
        b.r.drop = (drop > 63) ? 6'd63 : drop[5:0];
        b.run_end = 1'b0;
        if (step_beats.size() < RESULT_CAP) step_beats.insert(step_beats.size(), b);
    endfunction

    function automatic void shift_out(input int n);
        if (n >= shadow_fill) begin
            shadow_fill = 0;
            return;
        end
        for (int i = 0; i < shadow_fill - n; i++) shadow_bytes[i] = shadow_bytes[i + n];
        shadow_fill -= n;
    endfunction

    // Rescan the buffer until it has to wait for more bytes.
    function automatic void rescan();
        int h, n, p, keep, fsize, off, pay_lo, pay_hi;
        bit found;
        logic [31:0] encoded;
        longint total;
        while (shadow_fill != 0) begin
            h = hunt_len();
            n = shadow_fill;
            found = 1'b0;
            for (p = 0; p + h <= n; p++)
                if (header_at(p, h)) begin
                    found = 1'b1;
                    break;
                end
            if (!found) begin
                // keep a trailing partial header, drop the rest as noise
                keep = (n < h - 1) ? n : h - 1;
                for (; keep > 0; keep--)
                    if (header_at(n - keep, keep)) break;
                if (n - keep != 0) begin
                    add_beat(KIND_NOISE, 8'd0, 0, 0, n - keep);
                    shift_out(n - keep);
                end
                return;
            end
            if (p != 0) begin
                add_beat(KIND_NOISE, 8'd0, 0, 0, p);
                shift_out(p);
                continue;
            end
            fsize = live_cfg.fmt[3:2] + 1;
            off = live_cfg.len_off;
            if (n < off + fsize) return;
            encoded = '0;
            for (int i = 0; i < fsize; i++)
                if (live_cfg.fmt[0]) encoded |= 32'(shadow_bytes[off + i]) << (8 * i);
                else encoded = (encoded << 8) | 32'(shadow_bytes[off + i]);
            total = longint'(encoded) + (live_cfg.fmt[1] ? longint'(live_cfg.ovh) : 0);
            if (total == 0 || total > live_cfg.max_f || total < live_cfg.min_f) begin
                add_beat(KIND_BADLEN, 8'd0, 0, 0, 1);
                shift_out(1);
                continue;
            end
            if (n < total) return;
            if (live_cfg.fmt[1]) begin
                pay_lo = (live_cfg.pay_st == PAY_NONE) ? off + fsize : live_cfg.pay_st;
                pay_hi = (longint'(pay_lo) + encoded > total) ? int'(total)
                                                             : pay_lo + int'(encoded);
            end else if (live_cfg.pay_st != PAY_NONE) begin
                pay_lo = live_cfg.pay_st;
                pay_hi = int'(total);
            end else begin
                pay_lo = 0;
                pay_hi = 0;
            end
            for (int i = 0; i < total; i++)
                add_beat(KIND_FRAME, shadow_bytes[i], (i >= pay_lo && i < pay_hi),
                         (i + 1 == total), 0);
            shift_out(int'(total));
        end
    endfunction

    // Work out every result beat one accepted input byte causes.
    function automatic void predict_beats(input logic [7:0] data);
        step_beats.delete();
        rescan();
        while (shadow_fill >= STORE_BYTES) begin
            add_beat(KIND_OVF, 8'd0, 0, 0, 1);
            shift_out(1);
            rescan();
        end
        shadow_bytes[shadow_fill] = data;
        shadow_fill++;
        rescan();
        if (step_beats.size() > 0) step_beats[step_beats.size() - 1].run_end = 1'b1;
    endfunction

    // Register write with a setup phase, then an access phase; the register takes it at the access edge.
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic load_settings(input t_cfg c);
        reg_write(REG_HDR_PAT, c.hdr_pat);
        reg_write(REG_HDR_LEN, 32'(c.hdr_len));
        reg_write(REG_LEN_OFF, 32'(c.len_off));
        reg_write(REG_FORMAT, 32'(c.fmt));
        reg_write(REG_OVH, 32'(c.ovh));
        reg_write(REG_MIN, 32'(c.min_f));
        reg_write(REG_MAX, 32'(c.max_f));
        reg_write(REG_PAY_ST, 32'(c.pay_st));
        live_cfg = c;
    endtask

    // Wait for every expected beat, then let a hunt that yields nothing finish.
    task automatic settle();
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Offer one byte, idle first at random, and hold it until the beat is taken.
    task automatic push_byte(input logic [7:0] data, input bit typed = 1'b0,
                             input logic [1:0] kind = KIND_NOISE, input logic [5:0] drop = 0);
        t_beat b;
        if ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= data;
        do @(posedge i_clk); while (!o_in_ready);
        sent_count++;
        predict_beats(data);
        if (typed) begin
            // the report is plain enough to state directly
            b.r = '{kind: kind, data: 8'd0, pay: 1'b0, fend: 1'b0, drop: drop};
            b.run_end = 1'b1;
            pending_beats.insert(pending_beats.size(), b);
        end else begin
            foreach (step_beats[i]) pending_beats.insert(pending_beats.size(), step_beats[i]);
        end
    endtask

    // Build a live-settings frame, sometimes cut short, or noise at random or where none fits.
    task automatic push_random_chunk();
        int h, fsize, off, lo, hi, total, enc, kind_pick, len;
        logic [7:0] frame[STORE_BYTES];
        h = hunt_len();
        fsize = live_cfg.fmt[3:2] + 1;
        off = live_cfg.len_off;
        lo = (h > off + fsize) ? h : off + fsize;
        if (lo < live_cfg.min_f) lo = live_cfg.min_f;
        if (live_cfg.fmt[1] && lo < live_cfg.ovh) lo = live_cfg.ovh;
        hi = (live_cfg.max_f < STORE_BYTES) ? live_cfg.max_f : STORE_BYTES;
        kind_pick = $urandom_range(99);
        if (kind_pick >= 85) begin
            repeat ($urandom_range(4, 1)) push_byte(8'($urandom_range(255)));
            return;
        end
        if (lo > hi || lo < 1) begin
            // no frame can complete: lead with a header, then random content
            for (int i = 0; i < h; i++) push_byte(live_cfg.hdr_pat[8*i +: 8]);
            repeat ($urandom_range(8, 1)) push_byte(8'($urandom_range(255)));
            return;
        end
        total = $urandom_range(hi, lo);
        enc = live_cfg.fmt[1] ? total - live_cfg.ovh : total;
        for (int i = 0; i < total; i++) frame[i] = 8'($urandom_range(255));
        for (int i = 0; i < h; i++) frame[i] = live_cfg.hdr_pat[8*i +: 8];
        for (int i = 0; i < fsize; i++)
            frame[off + i] = live_cfg.fmt[0] ? 8'(enc >> (8 * i))
                                             : 8'(enc >> (8 * (fsize - 1 - i)));
        // a broken frame stops short and lets what follows resync it
        len = (kind_pick >= 70) ? $urandom_range(total - 1, 1) : total;
        if (len < 1) len = 1;
        for (int i = 0; i < len; i++) push_byte(frame[i]);
    endtask

    // Check every result beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_beats.size() == 0) begin
                report("unexpected beat kind", o_kind, -1);
            end else begin
                want = pending_beats.pop_front();
                if (o_kind != want.r.kind) report("kind", o_kind, want.r.kind);
                if (o_frame_byte != want.r.data) report("frame_byte", o_frame_byte, want.r.data);
                if (o_in_payload != want.r.pay) report("in_payload", o_in_payload, want.r.pay);
                if (o_frame_end != want.r.fend) report("frame_end", o_frame_end, want.r.fend);
                if (o_drop_count != want.r.drop) report("drop_count", o_drop_count, want.r.drop);
                if (o_run_end != want.run_end) report("run_end", o_run_end, want.run_end);
            end
        end
    end

    // Stall the result side at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    // Abort when neither channel has moved a beat for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    t_cfg phase_cfg[PHASE_COUNT];
    t_row dir_rows[$];

    initial begin
        int split;
        // defaults, then short/long headers, both byte orders, both length modes, extremes
        phase_cfg[0] = '{32'h0, 3'd1, 8'd0, 4'b0000, 8'd0, 16'd0, 16'hFFFF, 8'd255};
        phase_cfg[1] = '{32'h0000A55A, 3'd2, 8'd2, 4'b0000, 8'd0, 16'd4, 16'd20, 8'd3};
        phase_cfg[2] = '{32'h0000007E, 3'd1, 8'd1, 4'b0110, 8'd5, 16'd0, 16'hFFFF, 8'd255};
        phase_cfg[3] = '{32'hDEADBEEF, 3'd7, 8'd4, 4'b1111, 8'd3, 16'd8, 16'd32, 8'd2};
        phase_cfg[4] = '{32'h000000C3, 3'd0, 8'd1, 4'b1001, 8'd0, 16'd3, 16'd30, 8'd0};
        phase_cfg[5] = '{32'hFFFFFFFF, 3'd4, 8'd255, 4'b1111, 8'd255, 16'hFFFF, 16'd0,
                         8'd0};

        // after reset the header is one zero byte whose own length is zero;
        // second setting: good frame, short length, long length, noise, partial header
        dir_rows = '{
            '{8'hFF, 1, KIND_NOISE, 1}, '{8'h00, 1, KIND_BADLEN, 1},
            '{8'h80, 1, KIND_NOISE, 1}, '{8'h01, 1, KIND_NOISE, 1},
            '{8'h00, 1, KIND_BADLEN, 1}, '{8'h7F, 1, KIND_NOISE, 1},
            '{8'h5A, 0, 0, 0}, '{8'hA5, 0, 0, 0}, '{8'h06, 0, 0, 0}, '{8'h11, 0, 0, 0},
            '{8'h22, 0, 0, 0}, '{8'h33, 0, 0, 0}, '{8'h5A, 0, 0, 0}, '{8'hA5, 0, 0, 0},
            '{8'h02, 0, 0, 0}, '{8'h5A, 0, 0, 0}, '{8'hA5, 0, 0, 0}, '{8'hFF, 0, 0, 0},
            '{8'h00, 0, 0, 0}, '{8'h5A, 0, 0, 0}, '{8'hA5, 0, 0, 0}, '{8'h04, 0, 0, 0},
            '{8'h00, 0, 0, 0}, '{8'h5A, 0, 0, 0}};
        split = DEFAULT_ROWS;

        shadow_fill = 0;
        live_cfg = phase_cfg[0];
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        in_idle_pct = 33;
        out_stall_pct = 48;
        load_settings(phase_cfg[0]);
        foreach (dir_rows[i]) begin
            if (i == split) begin
                i_in_valid <= 1'b0;
                settle();
                load_settings(phase_cfg[1]);
            end
            push_byte(dir_rows[i].data, dir_rows[i].typed, dir_rows[i].kind,
                      dir_rows[i].drop);
        end

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            int base;
            // swap which side idles more halfway, then run flat out
            in_idle_pct = (ph < 2) ? 33 : (ph < 4) ? 48 : 0;
            out_stall_pct = (ph < 2) ? 48 : (ph < 4) ? 33 : 0;
            i_in_valid <= 1'b0;
            settle();
            load_settings(phase_cfg[ph]);
            base = sent_count;
            while (sent_count - base < RANDOM_BYTES) push_random_chunk();
        end
        i_in_valid <= 1'b0;

        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
